### rtl/core/assert_macros.svh
// Assertion macros shared by the framebuffer blit RTL.
// Assertions compile only when SYNTHESIS is not defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define FBRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define FBRB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBRB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/fbrb_pkg.sv
// Shared types and constants for the framebuffer rectangle blit.
// No dependencies; fbrb_chk, fbrb_ctrl and the top use it by scoped names.
package fbrb_pkg;

    localparam int SCREEN_WIDTH  = 400;
    localparam int SCREEN_HEIGHT = 300;
    localparam int FB_WORDS      = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FB_AW         = $clog2(FB_WORDS);
    localparam int ADDR_W        = 17;
    localparam int WORD_W        = 32;

    localparam logic [WORD_W-1:0] RAM_LOW_RST  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] RAM_HIGH_RST = 32'h87FF_FFFF;

    localparam logic [1:0] CTL_SCREEN = 2'd0;
    localparam logic [1:0] CTL_SYNC   = 2'd1;

    localparam logic CFG_RAM_LOW  = 1'b0;
    localparam logic CFG_RAM_HIGH = 1'b1;

    typedef enum logic [2:0] {
        CMD_DESC_WRITE = 3'd0,
        CMD_BLIT_START = 3'd1,
        CMD_PIXEL      = 3'd2,
        CMD_FB_WRITE   = 3'd3,
        CMD_FB_READ    = 3'd4,
        CMD_CTL_READ   = 3'd5,
        CMD_REFRESH    = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OFF_SCREEN = 3'd1,
        ST_SRC_RAM    = 3'd2,
        ST_PIXEL_IDLE = 3'd3,
        ST_BUSY       = 3'd4,
        ST_BAD_ADDR   = 3'd5
    } t_status;

    // Verdict of the start check unit.
    typedef struct packed {
        logic              off_screen;
        logic              empty;
        logic              src_bad;
        logic [FB_AW-1:0]  row_base;
        logic [ADDR_W-1:0] count;
    } t_chk_res;

endpackage

### rtl/core/fbrb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fbrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### rtl/core/fbrb_chk.sv
// Two-stage check unit for a blit start: screen fit, source range, row base.
// Depends on fbrb_pkg.
module fbrb_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_src,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_xy,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_wh,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_ram_low,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_ram_high,
    output logic                         o_done,
    output fbrb_pkg::t_chk_res           o_res
);

    logic        r_v1;
    logic        r_v2;
    logic        r_off;
    logic        r_empty;
    logic        r_src_out;
    logic [31:0] r_prod;
    logic [32:0] r_span;
    logic [15:0] r_x;
    logic [15:0] r_y;

    logic [15:0] x, y, w, h;
    logic [16:0] x_end, y_end;
    logic [33:0] bytes;
    logic [31:0] row_base_full;

    assign x = i_xy[15:0];
    assign y = i_xy[31:16];
    assign w = i_wh[15:0];
    assign h = i_wh[31:16];
    assign x_end = {1'b0, x} + {1'b0, w};
    assign y_end = {1'b0, y} + {1'b0, h};

    assign bytes = {r_prod, 2'b00};
    assign row_base_full = 32'(r_y) * 32'(fbrb_pkg::SCREEN_WIDTH) + 32'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1   <= i_go;
            r_v2   <= r_v1;
        end
        if (i_go) begin
            r_off     <= (x_end > 17'(fbrb_pkg::SCREEN_WIDTH))
                      || (y_end > 17'(fbrb_pkg::SCREEN_HEIGHT));
            r_empty   <= (w == 16'd0) || (h == 16'd0);
            r_src_out <= (i_src < i_ram_low) || (i_src > i_ram_high);
            r_prod    <= 32'(w) * 32'(h);
            r_span    <= {1'b0, i_ram_high} - {1'b0, i_src} + 33'd1;
            r_x       <= x;
            r_y       <= y;
        end
        if (r_v1) begin
            o_res.off_screen <= r_off;
            o_res.empty      <= r_empty;
            o_res.src_bad    <= r_src_out || (bytes > {1'b0, r_span});
            o_res.row_base   <= row_base_full[fbrb_pkg::FB_AW-1:0];
            o_res.count      <= r_prod[fbrb_pkg::ADDR_W-1:0];
        end
    end

    assign o_done = r_v2;

endmodule

### rtl/core/fbrb_ctrl.sv
// Command sequencer: framebuffer clearing sweep, descriptor and blit state,
// memory access and the result word register. Depends on fbrb_pkg.
module fbrb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_command,
    input  logic [1:0]                   i_reg_index,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_data,
    input  logic [fbrb_pkg::ADDR_W-1:0]  i_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fbrb_pkg::WORD_W-1:0]  o_read_data,
    output logic [2:0]                   o_status,
    output logic                         o_busy_res,
    output logic                         o_blit_done,
    output logic                         o_present,
    output logic                         o_fetch_valid,
    output logic [fbrb_pkg::WORD_W-1:0]  o_fetch_address,
    output logic [fbrb_pkg::ADDR_W-1:0]  o_fetch_count,
    output logic                         o_ram_we,
    output logic [fbrb_pkg::FB_AW-1:0]   o_ram_addr,
    output logic [fbrb_pkg::WORD_W-1:0]  o_ram_wdata,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_ram_rdata,
    output logic                         o_chk_go,
    output logic [fbrb_pkg::WORD_W-1:0]  o_chk_src,
    output logic [fbrb_pkg::WORD_W-1:0]  o_chk_xy,
    output logic [fbrb_pkg::WORD_W-1:0]  o_chk_wh,
    input  logic                         i_chk_done,
    input  fbrb_pkg::t_chk_res           i_chk_res
);

    localparam int AW = fbrb_pkg::FB_AW;
    localparam int WW = fbrb_pkg::WORD_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CHECK, S_READ} t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_cnt, n_clr_cnt;
    logic [WW-1:0]       r_desc [4];
    logic [WW-1:0]       n_desc [4];
    logic [WW-1:0]       r_sync, n_sync;
    logic                r_active, n_active;
    logic [15:0]         r_col, n_col;
    logic [15:0]         r_row, n_row;
    logic [AW-1:0]       r_row_base, n_row_base;

    logic                r_out_valid, n_out_valid;
    logic [WW-1:0]       r_out_read, n_out_read;
    logic [2:0]          r_out_status, n_out_status;
    logic                r_out_busy, n_out_busy;
    logic                r_out_done, n_out_done;
    logic                r_out_present, n_out_present;
    logic                r_out_fv, n_out_fv;
    logic [WW-1:0]       r_out_fa, n_out_fa;
    logic [fbrb_pkg::ADDR_W-1:0] r_out_fc, n_out_fc;

    logic                in_ready;
    logic                accept;
    logic                addr_ok;
    logic [AW:0]         pix_idx;
    logic [15:0]         col_inc;
    logic [15:0]         row_inc;

    logic                      load_out;
    logic [WW-1:0]             res_read;
    fbrb_pkg::t_status         res_status;
    logic                      res_done;
    logic                      res_present;
    logic                      res_fv;
    logic [WW-1:0]             res_fa;
    logic [fbrb_pkg::ADDR_W-1:0] res_fc;

    // A new word is taken only when the result register is empty or drains now.
    assign in_ready   = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !in_ready;
    assign accept     = i_in_valid && in_ready;

    assign addr_ok = 32'(i_address) < 32'(fbrb_pkg::FB_WORDS);
    assign pix_idx = {1'b0, r_row_base} + (AW + 1)'(r_col);
    assign col_inc = r_col + 16'd1;
    assign row_inc = r_row + 16'd1;

    assign o_chk_src = r_desc[0];
    assign o_chk_xy  = r_desc[1];
    assign o_chk_wh  = r_desc[2];

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_desc       = r_desc;
        n_sync       = r_sync;
        n_active     = r_active;
        n_col        = r_col;
        n_row        = r_row;
        n_row_base   = r_row_base;

        n_out_valid   = r_out_valid && i_out_stall;
        n_out_read    = r_out_read;
        n_out_status  = r_out_status;
        n_out_busy    = r_out_busy;
        n_out_done    = r_out_done;
        n_out_present = r_out_present;
        n_out_fv      = r_out_fv;
        n_out_fa      = r_out_fa;
        n_out_fc      = r_out_fc;

        o_ram_we    = 1'b0;
        o_ram_addr  = AW'(i_address);
        o_ram_wdata = i_data;
        o_chk_go    = 1'b0;

        load_out    = 1'b0;
        res_read    = '0;
        res_status  = fbrb_pkg::ST_OK;
        res_done    = 1'b0;
        res_present = 1'b0;
        res_fv      = 1'b0;
        res_fa      = '0;
        res_fc      = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_addr  = r_clr_cnt;
                o_ram_wdata = '0;
                n_clr_cnt   = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(fbrb_pkg::FB_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    load_out = 1'b1;
                    case (fbrb_pkg::t_cmd'(i_command))
                        fbrb_pkg::CMD_DESC_WRITE: begin
                            if (r_active) begin
                                res_status = fbrb_pkg::ST_BUSY;
                            end else begin
                                n_desc[i_reg_index] = i_data;
                            end
                        end
                        fbrb_pkg::CMD_BLIT_START: begin
                            if (r_active) begin
                                res_status = fbrb_pkg::ST_BUSY;
                            end else begin
                                load_out = 1'b0;
                                o_chk_go = 1'b1;
                                n_state  = S_CHECK;
                            end
                        end
                        fbrb_pkg::CMD_PIXEL: begin
                            if (!r_active) begin
                                res_status = fbrb_pkg::ST_PIXEL_IDLE;
                            end else begin
                                o_ram_addr = pix_idx[AW-1:0];
                                o_ram_we   = pix_idx < (AW + 1)'(fbrb_pkg::FB_WORDS);
                                n_col      = col_inc;
                                if (col_inc >= r_desc[2][15:0]) begin
                                    n_col      = '0;
                                    n_row      = row_inc;
                                    n_row_base = r_row_base + AW'(fbrb_pkg::SCREEN_WIDTH);
                                    if (row_inc >= r_desc[2][31:16]) begin
                                        n_active = 1'b0;
                                        n_sync   = r_desc[3];
                                        res_done = 1'b1;
                                    end
                                end
                            end
                        end
                        fbrb_pkg::CMD_FB_WRITE: begin
                            if (addr_ok) begin
                                o_ram_we = 1'b1;
                            end else begin
                                res_status = fbrb_pkg::ST_BAD_ADDR;
                            end
                        end
                        fbrb_pkg::CMD_FB_READ: begin
                            if (addr_ok) begin
                                load_out = 1'b0;
                                n_state  = S_READ;
                            end else begin
                                res_status = fbrb_pkg::ST_BAD_ADDR;
                            end
                        end
                        fbrb_pkg::CMD_CTL_READ: begin
                            if (i_reg_index == fbrb_pkg::CTL_SCREEN) begin
                                res_read = {16'(fbrb_pkg::SCREEN_WIDTH),
                                            16'(fbrb_pkg::SCREEN_HEIGHT)};
                            end else if (i_reg_index == fbrb_pkg::CTL_SYNC) begin
                                res_read = r_sync;
                            end else begin
                                res_status = fbrb_pkg::ST_BAD_ADDR;
                            end
                        end
                        fbrb_pkg::CMD_REFRESH: begin
                            if (r_sync != '0) begin
                                res_present = 1'b1;
                                n_sync      = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (i_chk_done) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (i_chk_res.off_screen) begin
                        res_status = fbrb_pkg::ST_OFF_SCREEN;
                    end else if (i_chk_res.empty) begin
                        n_sync   = r_desc[3];
                        res_done = 1'b1;
                    end else if (i_chk_res.src_bad) begin
                        res_status = fbrb_pkg::ST_SRC_RAM;
                    end else begin
                        n_active   = 1'b1;
                        n_col      = '0;
                        n_row      = '0;
                        n_row_base = i_chk_res.row_base;
                        res_fv     = 1'b1;
                        res_fa     = r_desc[0];
                        res_fc     = i_chk_res.count;
                    end
                end
            end
            S_READ: begin
                load_out = 1'b1;
                res_read = i_ram_rdata;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid   = 1'b1;
            n_out_read    = res_read;
            n_out_status  = res_status;
            n_out_busy    = n_active;
            n_out_done    = res_done;
            n_out_present = res_present;
            n_out_fv      = res_fv;
            n_out_fa      = res_fa;
            n_out_fc      = res_fc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_desc      <= '{default: '0};
            r_sync      <= '0;
            r_active    <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_row_base  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_desc      <= n_desc;
            r_sync      <= n_sync;
            r_active    <= n_active;
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_base  <= n_row_base;
            r_out_valid <= n_out_valid;
        end
        r_out_read    <= n_out_read;
        r_out_status  <= n_out_status;
        r_out_busy    <= n_out_busy;
        r_out_done    <= n_out_done;
        r_out_present <= n_out_present;
        r_out_fv      <= n_out_fv;
        r_out_fa      <= n_out_fa;
        r_out_fc      <= n_out_fc;
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_read;
    assign o_status        = r_out_status;
    assign o_busy_res      = r_out_busy;
    assign o_blit_done     = r_out_done;
    assign o_present       = r_out_present;
    assign o_fetch_valid   = r_out_fv;
    assign o_fetch_address = r_out_fa;
    assign o_fetch_count   = r_out_fc;

endmodule

### rtl/core/framebuffer_rect_blit_top.sv
// Framebuffer with rectangle blit. After reset the block sweeps the 120000-word
// framebuffer to zero, one word a cycle, and stalls input words until the sweep
// ends; configuration writes are taken at any time. Descriptor writes, pixel
// words, framebuffer writes, control reads and refresh ticks leave the block
// ready for the next word, so a blit's pixel words stream at one per cycle,
// while the receiver does not stall, into the single framebuffer RAM port. A
// framebuffer read waits for the registered RAM read, and a blit start for the
// check unit with its w*h and row base multipliers. Every input word yields
// exactly one result word, held in an output register while the receiver stalls.
// Depends on fbrb_pkg, fbrb_ram, fbrb_chk, fbrb_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module framebuffer_rect_blit_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_command,
    input  logic [1:0]                   i_reg_index,
    input  logic [fbrb_pkg::WORD_W-1:0]  i_data,
    input  logic [fbrb_pkg::ADDR_W-1:0]  i_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fbrb_pkg::WORD_W-1:0]  o_read_data,
    output logic [2:0]                   o_status,
    output logic                         o_busy_res,
    output logic                         o_blit_done,
    output logic                         o_present,
    output logic                         o_fetch_valid,
    output logic [fbrb_pkg::WORD_W-1:0]  o_fetch_address,
    output logic [fbrb_pkg::ADDR_W-1:0]  o_fetch_count
);

    logic [fbrb_pkg::WORD_W-1:0] r_ram_low;
    logic [fbrb_pkg::WORD_W-1:0] r_ram_high;

    logic                        ram_we;
    logic [fbrb_pkg::FB_AW-1:0]  ram_addr;
    logic [fbrb_pkg::WORD_W-1:0] ram_wdata;
    logic [fbrb_pkg::WORD_W-1:0] ram_rdata;

    logic                        chk_go;
    logic [fbrb_pkg::WORD_W-1:0] chk_src;
    logic [fbrb_pkg::WORD_W-1:0] chk_xy;
    logic [fbrb_pkg::WORD_W-1:0] chk_wh;
    logic                        chk_done;
    fbrb_pkg::t_chk_res          chk_res;

    logic                        fb_write_take;
    logic                        fetch_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_low  <= fbrb_pkg::RAM_LOW_RST;
            r_ram_high <= fbrb_pkg::RAM_HIGH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fbrb_pkg::CFG_RAM_LOW) begin
                r_ram_low <= i_cfg_data;
            end else begin
                r_ram_high <= i_cfg_data;
            end
        end
    end

    fbrb_ram #(
        .WIDTH (fbrb_pkg::WORD_W),
        .DEPTH (fbrb_pkg::FB_WORDS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    fbrb_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (chk_go),
        .i_src      (chk_src),
        .i_xy       (chk_xy),
        .i_wh       (chk_wh),
        .i_ram_low  (r_ram_low),
        .i_ram_high (r_ram_high),
        .o_done     (chk_done),
        .o_res      (chk_res)
    );

    fbrb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_reg_index     (i_reg_index),
        .i_data          (i_data),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_data     (o_read_data),
        .o_status        (o_status),
        .o_busy_res      (o_busy_res),
        .o_blit_done     (o_blit_done),
        .o_present       (o_present),
        .o_fetch_valid   (o_fetch_valid),
        .o_fetch_address (o_fetch_address),
        .o_fetch_count   (o_fetch_count),
        .o_ram_we        (ram_we),
        .o_ram_addr      (ram_addr),
        .o_ram_wdata     (ram_wdata),
        .i_ram_rdata     (ram_rdata),
        .o_chk_go        (chk_go),
        .o_chk_src       (chk_src),
        .o_chk_xy        (chk_xy),
        .o_chk_wh        (chk_wh),
        .i_chk_done      (chk_done),
        .i_chk_res       (chk_res)
    );

    assign fb_write_take = i_in_valid && !o_in_stall
                        && (i_command == 3'(fbrb_pkg::CMD_FB_WRITE));
    assign fetch_ok      = o_busy_res && (o_status == 3'(fbrb_pkg::ST_OK))
                        && (o_fetch_count != '0);

    // No input word is taken while a finished result is held back.
    `FBRB_ASSERT_IMP(a_no_take_when_full, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    // A framebuffer write answers in the very next cycle.
    `FBRB_ASSERT_NXT(a_fb_write_result, i_clk, i_rst_n, fb_write_take, o_out_valid)
    // An issued fetch starts a blit and is never an error.
    `FBRB_ASSERT_IMP(a_fetch_busy, i_clk, i_rst_n, o_out_valid && o_fetch_valid, fetch_ok)
    // A finished blit leaves the block idle.
    `FBRB_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_out_valid && o_blit_done, !o_busy_res)

endmodule

### bench/tb_framebuffer_rect_blit_top.sv
`timescale 1ns / 100ps
// Self-checking bench for framebuffer_rect_blit_top; a scoreboard class predicts each word.
// Stimulus is directed corner cases, then random blits and noise under six RAM windows.
// Depends on fbrb_pkg and the framebuffer_rect_blit_top RTL only.

module tb_framebuffer_rect_blit_top;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam logic [1:0] CTL_SPARE    = 2'd3;
    localparam logic [1:0] DESC_SOURCE  = 2'd0;
    localparam logic [1:0] DESC_XY      = 2'd1;
    localparam logic [1:0] DESC_WH      = 2'd2;
    localparam logic [1:0] DESC_SYNC    = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         TAIL_CYCLES  = 32;
    localparam int         SCR_W        = fbrb_pkg::SCREEN_WIDTH;
    localparam int         SCR_H        = fbrb_pkg::SCREEN_HEIGHT;
    localparam int         FB_WORDS     = fbrb_pkg::FB_WORDS;

    typedef enum {SHAPE_RANDOM, SHAPE_FULL_ROW, SHAPE_FULL_COLUMN} t_shape;
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_RUNS} t_flow_mode;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
        logic        busy;
        logic        done;
        logic        present;
        logic        fetch_valid;
        logic [31:0] fetch_address;
        logic [16:0] fetch_count;
    } t_blit_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = 1'b0;
    logic [fbrb_pkg::WORD_W-1:0]   i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_command = '0;
    logic [1:0]                    i_reg_index = '0;
    logic [fbrb_pkg::WORD_W-1:0]   i_data = '0;
    logic [fbrb_pkg::ADDR_W-1:0]   i_address = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [fbrb_pkg::WORD_W-1:0]   o_read_data;
    logic [2:0]                    o_status;
    logic                          o_busy_res;
    logic                          o_blit_done;
    logic                          o_present;
    logic                          o_fetch_valid;
    logic [fbrb_pkg::WORD_W-1:0]   o_fetch_address;
    logic [fbrb_pkg::ADDR_W-1:0]   o_fetch_count;

    framebuffer_rect_blit_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_reg_index     (i_reg_index),
        .i_data          (i_data),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_data     (o_read_data),
        .o_status        (o_status),
        .o_busy_res      (o_busy_res),
        .o_blit_done     (o_blit_done),
        .o_present       (o_present),
        .o_fetch_valid   (o_fetch_valid),
        .o_fetch_address (o_fetch_address),
        .o_fetch_count   (o_fetch_count)
    );

    class blit_scoreboard;
        bit [31:0]   frame_words [FB_WORDS];
        bit [31:0]   descriptor [4];
        bit [31:0]   sync_word;
        bit          active;
        int unsigned col_count;
        int unsigned row_count;
        int unsigned row_base;
        bit [31:0]   ram_low = fbrb_pkg::RAM_LOW_RST;
        bit [31:0]   ram_high = fbrb_pkg::RAM_HIGH_RST;
        t_blit_word  awaited_results [$];
        int          mismatches;
        int          words_seen;
        int          blits_finished;
        int          fetches;
        int          presents;
        int          error_words;

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void end_blit();
            active = 1'b0;
            sync_word = descriptor[DESC_SYNC];
            blits_finished++;
        endfunction

        // Works out the result word that an accepted input word must produce.
        function void note_word(logic [2:0] cmd, logic [1:0] idx, logic [31:0] data,
                                logic [16:0] addr);
            t_blit_word      r;
            int unsigned     x, y, w, h, pix_index;
            longint unsigned need, room;
            r = '0;
            words_seen++;
            case (cmd)
                fbrb_pkg::CMD_DESC_WRITE: begin
                    if (active) r.status = fbrb_pkg::ST_BUSY;
                    else descriptor[idx] = data;
                end
                fbrb_pkg::CMD_BLIT_START: begin
                    x = descriptor[DESC_XY][15:0];
                    y = descriptor[DESC_XY][31:16];
                    w = descriptor[DESC_WH][15:0];
                    h = descriptor[DESC_WH][31:16];
                    need = 64'(w) * 64'(h) * 64'd4;
                    room = 64'(ram_high) - 64'(descriptor[DESC_SOURCE]) + 64'd1;
                    if (active) begin
                        r.status = fbrb_pkg::ST_BUSY;
                    end else if (x + w > SCR_W || y + h > SCR_H) begin
                        r.status = fbrb_pkg::ST_OFF_SCREEN;
                    end else if (w == 0 || h == 0) begin
                        end_blit();
                        r.done = 1'b1;
                    end else if (descriptor[DESC_SOURCE] < ram_low ||
                                 descriptor[DESC_SOURCE] > ram_high || need > room) begin
                        r.status = fbrb_pkg::ST_SRC_RAM;
                    end else begin
                        active = 1'b1;
                        col_count = 0;
                        row_count = 0;
                        row_base = y * SCR_W + x;
                        r.fetch_valid = 1'b1;
                        r.fetch_address = descriptor[DESC_SOURCE];
                        r.fetch_count = 17'(w * h);
                        fetches++;
                    end
                end
                fbrb_pkg::CMD_PIXEL: begin
                    if (!active) begin
                        r.status = fbrb_pkg::ST_PIXEL_IDLE;
                    end else begin
                        w = descriptor[DESC_WH][15:0];
                        h = descriptor[DESC_WH][31:16];
                        pix_index = row_base + col_count;
                        if (pix_index < FB_WORDS) frame_words[pix_index] = data;
                        col_count++;
                        if (col_count >= w) begin
                            col_count = 0;
                            row_count++;
                            row_base += SCR_W;
                            if (row_count >= h) begin
                                end_blit();
                                r.done = 1'b1;
                            end
                        end
                    end
                end
                fbrb_pkg::CMD_FB_WRITE: begin
                    if (addr < FB_WORDS) frame_words[addr] = data;
                    else r.status = fbrb_pkg::ST_BAD_ADDR;
                end
                fbrb_pkg::CMD_FB_READ: begin
                    if (addr < FB_WORDS) r.read_data = frame_words[addr];
                    else r.status = fbrb_pkg::ST_BAD_ADDR;
                end
                fbrb_pkg::CMD_CTL_READ: begin
                    if (idx == fbrb_pkg::CTL_SCREEN) r.read_data = {16'(SCR_W), 16'(SCR_H)};
                    else if (idx == fbrb_pkg::CTL_SYNC) r.read_data = sync_word;
                    else r.status = fbrb_pkg::ST_BAD_ADDR;
                end
                fbrb_pkg::CMD_REFRESH: begin
                    if (sync_word != 0) begin
                        r.present = 1'b1;
                        sync_word = '0;
                        presents++;
                    end
                end
                default: ;
            endcase
            if (r.status != fbrb_pkg::ST_OK) error_words++;
            r.busy = active;
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 100)
                $display("MISMATCH at %0t: %s got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_result(t_blit_word got);
            t_blit_word want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result word with nothing awaited", 32'(got.status), '0);
                return;
            end
            want = awaited_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.busy !== want.busy)
                report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
            if (got.done !== want.done)
                report_mismatch("blit_done", 32'(got.done), 32'(want.done));
            if (got.present !== want.present)
                report_mismatch("present", 32'(got.present), 32'(want.present));
            if (got.fetch_valid !== want.fetch_valid)
                report_mismatch("fetch_valid", 32'(got.fetch_valid), 32'(want.fetch_valid));
            if (got.fetch_address !== want.fetch_address)
                report_mismatch("fetch_address", got.fetch_address, want.fetch_address);
            if (got.fetch_count !== want.fetch_count)
                report_mismatch("fetch_count", 32'(got.fetch_count), 32'(want.fetch_count));
        endtask
    endclass

    blit_scoreboard board = new();
    int unsigned    burst_left = 0;
    int             cycle_count = 0;
    t_flow_mode     flow_mode = FLOW_FREE;
    int unsigned    flow_left = 0;
    int unsigned    run_left = 0;
    t_blit_word     seen_word;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results awaited",
                     cycle_count, board.outstanding());
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver switches at random among four stall habits: free, light, heavy and runs.
    always @(posedge i_clk) begin
        if (flow_left == 0) begin
            flow_mode <= t_flow_mode'($urandom_range(0, 3));
            flow_left <= $urandom_range(64, 256);
        end else begin
            flow_left <= flow_left - 1;
        end
        case (flow_mode)
            FLOW_FREE:  i_out_stall <= 1'b0;
            FLOW_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
            FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
            default: begin
                if (run_left == 0) begin
                    i_out_stall <= !i_out_stall;
                    run_left <= $urandom_range(1, 10);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // Outputs are sampled mid-cycle, where they are settled; the word moves at the next edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            seen_word = {o_read_data, o_status, o_busy_res, o_blit_done, o_present,
                         o_fetch_valid, o_fetch_address, o_fetch_count};
            board.check_result(seen_word);
        end
    end

    task automatic send_word(input logic [2:0] cmd, input logic [1:0] idx,
                             input logic [31:0] data, input logic [16:0] addr);
        int unsigned gap;
        bit          taken;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_reg_index <= idx;
        i_data      <= data;
        i_address   <= addr;
        do begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        board.note_word(cmd, idx, data, addr);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    task automatic configure_window(input logic [31:0] lo, input logic [31:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fbrb_pkg::CFG_RAM_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= fbrb_pkg::CFG_RAM_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.ram_low  = lo;
        board.ram_high = hi;
    endtask

    function automatic logic [16:0] random_address();
        case ($urandom_range(0, 3))
            0:       return 17'($urandom);
            1:       return 17'(FB_WORDS - 1 + $urandom_range(0, 1));
            default: return 17'($urandom_range(0, FB_WORDS - 1));
        endcase
    endfunction

    function automatic logic [16:0] rect_address(int unsigned x, int unsigned y,
                                                 int unsigned w, int unsigned h);
        return 17'((y + $urandom_range(0, h - 1)) * SCR_W + x + $urandom_range(0, w - 1));
    endfunction

    // One descriptor set, a start, the pixel stream with other traffic mixed in, then read-back.
    task automatic run_blit_sequence(input t_shape shape);
        int unsigned     w, h, x, y, pick, k, idx;
        longint unsigned lo, hi, span, need;
        logic [31:0]     src;
        logic [31:0]     words [4];
        bit              reverse;
        pick = $urandom_range(0, 99);
        if (shape == SHAPE_FULL_ROW) begin
            w = SCR_W;
            h = 1;
        end else if (shape == SHAPE_FULL_COLUMN) begin
            w = 1;
            h = SCR_H;
        end else if (pick < 6) begin
            // Empty rectangle: one side zero, the other anything that fits.
            w = $urandom_range(0, SCR_W);
            h = $urandom_range(0, SCR_H);
            if (pick < 3) w = 0;
            else h = 0;
        end else if (pick < 12) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
        end else if (pick < 40) begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 3);
        end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
        end
        x = ($urandom_range(0, 3) == 0) ? SCR_W - w : $urandom_range(0, SCR_W - w);
        y = ($urandom_range(0, 3) == 0) ? SCR_H - h : $urandom_range(0, SCR_H - h);
        if (shape == SHAPE_RANDOM && pick >= 6 && pick < 12) begin
            // Push the rectangle past an edge, or make every field wild.
            case (pick % 3)
                0: x = SCR_W - w + $urandom_range(1, 8);
                1: y = SCR_H - h + $urandom_range(1, 8);
                default: begin
                    x = $urandom_range(0, 16'hFFFF);
                    y = $urandom_range(0, 16'hFFFF);
                    w = $urandom_range(0, 16'hFFFF);
                    h = $urandom_range(0, 16'hFFFF);
                end
            endcase
        end

        lo = board.ram_low;
        hi = board.ram_high;
        need = 64'(w) * 64'(h) * 64'd4;
        span = (hi >= lo) ? hi - lo + 1 : 0;
        if (span >= need && $urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 3))
                0:       src = 32'(lo);
                1:       src = 32'(hi - need + 1);
                default: src = 32'(lo + ({$urandom, $urandom} % (span - need + 1)));
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       src = 32'(lo - 1);
                1:       src = 32'(hi - need + 2);
                2:       src = 32'(hi + 1);
                default: src = $urandom;
            endcase
        end
        words[DESC_SOURCE] = src;
        words[DESC_XY]     = {y[15:0], x[15:0]};
        words[DESC_WH]     = {h[15:0], w[15:0]};
        words[DESC_SYNC]   = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;

        // A start from the noise traffic may have left a blit open.
        while (board.active)
            send_word(fbrb_pkg::CMD_PIXEL, 2'($urandom), $urandom, random_address());

        reverse = $urandom_range(0, 1);
        for (k = 0; k < 4; k++) begin
            idx = reverse ? 3 - k : k;
            send_word(fbrb_pkg::CMD_DESC_WRITE, 2'(idx), words[idx], random_address());
        end
        send_word(fbrb_pkg::CMD_BLIT_START, 2'($urandom), $urandom, random_address());

        while (board.active) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 5))
                    0: send_word(fbrb_pkg::CMD_FB_WRITE, 2'($urandom), $urandom,
                                 rect_address(x, y, w, h));
                    1: send_word(fbrb_pkg::CMD_FB_READ, 2'($urandom), $urandom,
                                 random_address());
                    2: send_word(fbrb_pkg::CMD_CTL_READ, 2'($urandom), $urandom,
                                 random_address());
                    3: send_word(fbrb_pkg::CMD_REFRESH, 2'($urandom), $urandom,
                                 random_address());
                    4: send_word(fbrb_pkg::CMD_DESC_WRITE, 2'($urandom), $urandom,
                                 random_address());
                    default: send_word(fbrb_pkg::CMD_BLIT_START, 2'($urandom), $urandom,
                                       random_address());
                endcase
            end else begin
                send_word(fbrb_pkg::CMD_PIXEL, 2'($urandom), $urandom, random_address());
            end
        end

        if ($urandom_range(0, 7) == 0)
            send_word(fbrb_pkg::CMD_PIXEL, 2'($urandom), $urandom, random_address());
        if ($urandom_range(0, 1) == 0)
            send_word(fbrb_pkg::CMD_CTL_READ, fbrb_pkg::CTL_SYNC, $urandom, random_address());
        if ($urandom_range(0, 1) == 0)
            send_word(fbrb_pkg::CMD_REFRESH, 2'($urandom), $urandom, random_address());
        if (w != 0 && h != 0 && x + w <= SCR_W && y + h <= SCR_H)
            repeat (2) send_word(fbrb_pkg::CMD_FB_READ, 2'($urandom), $urandom,
                                 rect_address(x, y, w, h));
    endtask

    initial begin
        logic [31:0] lows [6];
        logic [31:0] highs [6];
        int          quotas [6];
        int          p, goal, half;
        bit          paused;

        lows   = '{fbrb_pkg::RAM_LOW_RST, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0, 32'h0000_1000};
        highs  = '{fbrb_pkg::RAM_HIGH_RST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0, 32'h0000_1FFF};
        quotas = '{40, 700, 25, 25, 40, 30};
        lows[4]  = $urandom;
        highs[4] = 32'(lows[4] + $urandom_range(0, 4096));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The window may be written while the framebuffer is still being swept.
        configure_window(fbrb_pkg::RAM_LOW_RST, fbrb_pkg::RAM_HIGH_RST);

        send_word(fbrb_pkg::CMD_CTL_READ, fbrb_pkg::CTL_SCREEN, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_CTL_READ, fbrb_pkg::CTL_SYNC, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_CTL_READ, CTL_SPARE, 32'hFFFF_FFFF, 17'h1FFFF);
        send_word(fbrb_pkg::CMD_FB_WRITE, 2'd0, 32'hFFFF_FFFF, 17'(FB_WORDS - 1));
        send_word(fbrb_pkg::CMD_FB_READ, 2'd0, 32'd0, 17'(FB_WORDS - 1));
        send_word(fbrb_pkg::CMD_FB_READ, 2'd0, 32'd0, 17'(FB_WORDS));
        send_word(fbrb_pkg::CMD_FB_WRITE, 2'd3, 32'h1234_5678, 17'h1FFFF);
        send_word(fbrb_pkg::CMD_PIXEL, 2'd0, 32'hDEAD_BEEF, 17'd0);
        send_word(fbrb_pkg::CMD_REFRESH, 2'd0, 32'd0, 17'd0);
        send_word(CMD_UNUSED, 2'd3, 32'hFFFF_FFFF, 17'h1FFFF);
        // A one-pixel blit at the bottom right corner whose source ends on the last RAM byte.
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_SOURCE, fbrb_pkg::RAM_HIGH_RST - 32'd3, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_XY, {16'd299, 16'd399}, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_WH, {16'd1, 16'd1}, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_SYNC, 32'hFFFF_FFFF, 17'd0);
        send_word(fbrb_pkg::CMD_BLIT_START, 2'd0, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_XY, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_BLIT_START, 2'd0, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_PIXEL, 2'd0, 32'h0000_0000, 17'd0);
        send_word(fbrb_pkg::CMD_CTL_READ, fbrb_pkg::CTL_SYNC, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_REFRESH, 2'd0, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_WH, {16'd1, 16'd2}, 17'd0);
        send_word(fbrb_pkg::CMD_BLIT_START, 2'd0, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_WH, 32'd0, 17'd0);
        send_word(fbrb_pkg::CMD_BLIT_START, 2'd0, 32'd0, 17'd0);
        // A one-pixel source that runs one byte past the end of RAM.
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_SOURCE, fbrb_pkg::RAM_HIGH_RST - 32'd2, 17'd0);
        send_word(fbrb_pkg::CMD_DESC_WRITE, DESC_WH, {16'd1, 16'd1}, 17'd0);
        send_word(fbrb_pkg::CMD_BLIT_START, 2'd0, 32'd0, 17'd0);

        for (p = 0; p < 6; p++) begin
            wait_for_results();
            configure_window(lows[p], highs[p]);
            goal = board.words_seen + quotas[p];
            half = board.words_seen + quotas[p] / 2;
            paused = 1'b0;
            if (p == 1) begin
                run_blit_sequence(SHAPE_FULL_ROW);
                run_blit_sequence(SHAPE_FULL_COLUMN);
            end
            while (board.words_seen < goal) begin
                if (!paused && board.words_seen >= half) begin
                    wait_for_results();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4))
                        send_word(3'($urandom_range(0, 7)), 2'($urandom), $urandom,
                                  random_address());
                else
                    run_blit_sequence(SHAPE_RANDOM);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d input words over six RAM windows: %0d fetches, %0d blits done,",
                 board.words_seen, board.fetches, board.blits_finished);
        $display("%0d presents and %0d error statuses; %0d mismatches.",
                 board.presents, board.error_words, board.mismatches);
        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
